// ===== sv/fnswc_pkg.sv =====
// ----------------------------------------------------------------------------
// fnswc_pkg: shared types and constants of the synthesizer word calculator
// Field widths, band thresholds, band numbers and the divide-by-three
// reciprocal used to form the phase-detector frequency.
// ----------------------------------------------------------------------------
`default_nettype none

package fnswc_pkg;

  localparam int FREQ_W  = 30;   // target frequency field
  localparam int REF_W   = 26;   // reference clock register
  localparam int PFD_W   = 25;   // pfd <= ref/2 always fits here
  localparam int BAND_W  = 4;
  localparam int INT_W   = 8;
  localparam int FRAC_W  = 20;

  localparam int FRACTION_BITS_DEFAULT = 19;

  localparam logic [FREQ_W-1:0] LIMIT_TOP = 30'd705000000;
  localparam logic [FREQ_W-1:0] LIMIT_B1  = 30'd525000000;
  localparam logic [FREQ_W-1:0] LIMIT_B2  = 30'd353000000;
  localparam logic [FREQ_W-1:0] LIMIT_B3  = 30'd239000000;
  localparam logic [FREQ_W-1:0] LIMIT_B4  = 30'd177000000;
  localparam logic [REF_W-1:0]  REF_SPLIT = 26'd24000000;
  localparam logic [REF_W-1:0]  REF_RESET = 26'd26000000;

  localparam logic [BAND_W-1:0] BAND_OFFSET = 4'd8;

  // floor(x/3) == (x * ceil(2^28/3)) >> 28 for every x below 2^26
  localparam int                  THIRD_MUL_W = 27;
  localparam int                  THIRD_SHIFT = 28;
  localparam logic [THIRD_MUL_W-1:0] THIRD_MUL = 27'd89478486;

  // Band number; each one fixes the output divider as well
  typedef enum logic [2:0] {
    BAND_0 = 3'd0,   // outdiv 4
    BAND_1 = 3'd1,   // outdiv 6
    BAND_2 = 3'd2,   // outdiv 8
    BAND_3 = 3'd3,   // outdiv 12
    BAND_4 = 3'd4,   // outdiv 16
    BAND_5 = 3'd5    // outdiv 24
  } band_t;

endpackage

`default_nettype wire

// ===== sv/fractional_n_synth_word_calc.sv =====
// ----------------------------------------------------------------------------
// fractional_n_synth_word_calc: fractional-N divider word calculator
// Turns a carrier frequency into band code, integer word and fraction word.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (freq_valid / freq_stall / target_freq_hz): one word per
//   carrier frequency in hertz. Result channel (word_valid / word_stall /
//   band_code, integer_word, fraction_word, range_error): one word back per
//   request, in request order.
//   reference_clock_hz is written over its own valid/ready channel; ready is
//   always high. Write it only while no request is in flight.
//   From acceptance to word_valid a request passes one band decode /
//   reciprocal multiply stage, one pfd select stage, 30 + FRACTION_BITS
//   restoring divider stages (one quotient bit each) and the output
//   register.
//   Throughput: one request per cycle unless a stall holds the pipeline. Every
//   stage moves on a shared enable; the divider chain is what sets the depth.
//   Stall: while a result waits with word_stall high the whole pipeline holds
//   and freq_stall is raised; nothing is dropped or repeated.
//   Reset (rst, synchronous): clears all valid bits and loads the reference
//   clock register with 26 MHz.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_n_synth_word_calc #(
  parameter int FRACTION_BITS = fnswc_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fnswc_pkg::REF_W-1:0]    reference_clock_hz,
  // requests
  input  wire logic                           freq_valid,
  output logic                                freq_stall,
  input  wire logic [fnswc_pkg::FREQ_W-1:0]   target_freq_hz,
  // results
  output logic                                word_valid,
  input  wire logic                           word_stall,
  output logic [fnswc_pkg::BAND_W-1:0]        band_code,
  output logic [fnswc_pkg::INT_W-1:0]         integer_word,
  output logic [fnswc_pkg::FRAC_W-1:0]        fraction_word,
  output logic                                range_error
);

  import fnswc_pkg::*;

  // Dividend is freq followed by FRACTION_BITS zeros, so one long divide
  // yields q in the top bits and floor(r * 2^FB / pfd) in the low bits.
  localparam int DIV_W = FREQ_W + FRACTION_BITS;

  logic adv;

  // reference clock register
  logic [REF_W-1:0] ref_clk;

  // stage 1: band decode and reciprocal multiply
  logic                          s1_valid;
  logic [FREQ_W-1:0]             s1_freq;
  logic [REF_W-1:0]              s1_ref;
  logic [REF_W+THIRD_MUL_W-1:0]  s1_prod;
  band_t                         s1_band;
  logic                          s1_err;
  band_t                         band_sel;

  // divider stages, index 0 is loaded by the pfd select stage
  logic                 stg_valid [0:DIV_W];
  logic [FREQ_W-1:0]    stg_freq  [0:DIV_W];
  logic [PFD_W-1:0]     stg_pfd   [0:DIV_W];
  logic [PFD_W-1:0]     stg_rem   [0:DIV_W];
  logic [DIV_W-1:0]     stg_quo   [0:DIV_W];
  band_t                stg_band  [0:DIV_W];
  logic                 stg_err   [0:DIV_W];

  logic [PFD_W-1:0]     third;
  logic [PFD_W-1:0]     pfd_sel;

  // final stage
  logic [FREQ_W-1:0]           quot;
  logic [FRACTION_BITS:0]      frac_full;
  logic [FRACTION_BITS+20:0]   frac_ext;
  logic                        fin_err;

  // Hold everything while a finished word is refused downstream
  assign adv        = !(word_valid && word_stall);
  assign freq_stall = !adv;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clk <= REF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ref_clk <= reference_clock_hz;
    end
  end

  // Band select from the frequency thresholds; the middle range splits on
  // the reference clock.
  always_comb begin
    if (target_freq_hz < LIMIT_B4) begin
      band_sel = BAND_5;
    end else if (target_freq_hz < LIMIT_B3) begin
      band_sel = BAND_4;
    end else if (target_freq_hz < LIMIT_B2) begin
      band_sel = BAND_3;
    end else if (target_freq_hz < LIMIT_B1) begin
      band_sel = (ref_clk < REF_SPLIT) ? BAND_0 : BAND_2;
    end else begin
      band_sel = BAND_1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= freq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_freq <= target_freq_hz;
      s1_ref  <= ref_clk;
      s1_prod <= {{THIRD_MUL_W{1'b0}}, ref_clk} * {{REF_W{1'b0}}, THIRD_MUL};
      s1_band <= band_sel;
      s1_err  <= (target_freq_hz >= LIMIT_TOP);
    end
  end

  // stage 2: pfd = floor(2 * ref / outdiv)
  assign third = s1_prod[THIRD_SHIFT +: PFD_W];

  always_comb begin
    case (s1_band)
      BAND_0:  pfd_sel = PFD_W'(s1_ref >> 1);
      BAND_2:  pfd_sel = PFD_W'(s1_ref >> 2);
      BAND_4:  pfd_sel = PFD_W'(s1_ref >> 3);
      BAND_1:  pfd_sel = third;
      BAND_3:  pfd_sel = third >> 1;
      BAND_5:  pfd_sel = third >> 2;
      default: pfd_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (adv) begin
      stg_valid[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_freq[0] <= s1_freq;
      stg_pfd[0]  <= pfd_sel;
      stg_rem[0]  <= '0;
      stg_quo[0]  <= '0;
      stg_band[0] <= s1_band;
      stg_err[0]  <= s1_err || (pfd_sel == '0);
    end
  end

  // Restoring divider: one quotient bit per stage
  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic             dbit;
    logic [PFD_W:0]   trial;
    logic             ge;

    if (k < FREQ_W) begin : g_fbit
      assign dbit = stg_freq[k][FREQ_W-1-k];
    end else begin : g_zbit
      assign dbit = 1'b0;
    end

    assign trial = {stg_rem[k], dbit};
    assign ge    = (trial >= {1'b0, stg_pfd[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k+1] <= 1'b0;
      end else if (adv) begin
        stg_valid[k+1] <= stg_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_freq[k+1] <= stg_freq[k];
        stg_pfd[k+1]  <= stg_pfd[k];
        stg_rem[k+1]  <= ge ? PFD_W'(trial - {1'b0, stg_pfd[k]}) : trial[PFD_W-1:0];
        stg_quo[k+1]  <= {stg_quo[k][DIV_W-2:0], ge};
        stg_band[k+1] <= stg_band[k];
        stg_err[k+1]  <= stg_err[k];
      end
    end
  end

  // Output: a zero quotient is also out of range; zero all fields on error
  assign quot      = stg_quo[DIV_W][DIV_W-1:FRACTION_BITS];
  assign frac_full = {1'b1, stg_quo[DIV_W][FRACTION_BITS-1:0]};
  assign frac_ext  = {20'd0, frac_full};
  assign fin_err   = stg_err[DIV_W] || (quot == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (adv) begin
      word_valid <= stg_valid[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      range_error   <= fin_err;
      band_code     <= fin_err ? '0 : BAND_W'(stg_band[DIV_W]) + BAND_OFFSET;
      integer_word  <= fin_err ? '0 : quot[INT_W-1:0] - INT_W'(1);
      fraction_word <= fin_err ? '0 : frac_ext[FRAC_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/fnswc_checker.sv =====
// ----------------------------------------------------------------------------
// fnswc_checker: port-level checks of the synthesizer word calculator
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module fnswc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [fnswc_pkg::REF_W-1:0]    reference_clock_hz,
  input wire logic                           freq_valid,
  input wire logic                           freq_stall,
  input wire logic [fnswc_pkg::FREQ_W-1:0]   target_freq_hz,
  input wire logic                           word_valid,
  input wire logic                           word_stall,
  input wire logic [fnswc_pkg::BAND_W-1:0]   band_code,
  input wire logic [fnswc_pkg::INT_W-1:0]    integer_word,
  input wire logic [fnswc_pkg::FRAC_W-1:0]   fraction_word,
  input wire logic                           range_error
);

  import fnswc_pkg::*;

  // a refused word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_stall |=> word_valid)
    else $error("result word dropped while stalled");

  // a refused result must back-pressure the request side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_stall |-> freq_stall)
    else $error("request accepted while result stalled");

  // error words carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    word_valid && range_error |->
      band_code == '0 && integer_word == '0 && fraction_word == '0)
    else $error("error word with nonzero fields");

  // good words carry a band code in the legal span
  a_band_span: assert property (@(posedge clk) disable iff (rst)
    word_valid && !range_error |->
      band_code >= BAND_OFFSET && band_code <= BAND_OFFSET + BAND_W'(BAND_5))
    else $error("band code out of span");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !word_valid)
    else $error("result word valid right after reset");

endmodule

bind fractional_n_synth_word_calc fnswc_checker u_fnswc_checker (.*);

`default_nettype wire

// ===== verif/fnswc_word_checker.sv =====
// ----------------------------------------------------------------------------
// fnswc_word_checker: scoreboard for the synthesizer word calculator
// Watches the configuration, request and result channels, works out the
// expected band code, integer word, fraction word and range error for every
// accepted request and compares them with the words that come back.
// ----------------------------------------------------------------------------
`default_nettype none

module fnswc_word_checker #(
  parameter int FRACTION_BITS = fnswc_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [fnswc_pkg::REF_W-1:0]  reference_clock_hz,
  input  wire logic                         freq_valid,
  input  wire logic                         freq_stall,
  input  wire logic [fnswc_pkg::FREQ_W-1:0] target_freq_hz,
  input  wire logic                         word_valid,
  input  wire logic                         word_stall,
  input  wire logic [fnswc_pkg::BAND_W-1:0] band_code,
  input  wire logic [fnswc_pkg::INT_W-1:0]  integer_word,
  input  wire logic [fnswc_pkg::FRAC_W-1:0] fraction_word,
  input  wire logic                         range_error,
  output int                                pending,
  output int                                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import fnswc_pkg::*;

  typedef struct packed {
    logic [BAND_W-1:0] band_code;
    logic [INT_W-1:0]  integer_word;
    logic [FRAC_W-1:0] fraction_word;
    logic              range_error;
  } synth_word_t;

  synth_word_t       divider_words_q[$];
  logic [REF_W-1:0]  ref_hz;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // Band pick, pfd, quotient and remainder for one carrier frequency
  function automatic synth_word_t calc_divider_word(input logic [FREQ_W-1:0] freq,
                                                    input logic [REF_W-1:0]  refclk);
    synth_word_t w;
    band_t       band;
    logic [63:0] outdiv;
    logic [63:0] pfd;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] frac;
    w = '{band_code: '0, integer_word: '0, fraction_word: '0, range_error: 1'b1};
    if (freq >= LIMIT_TOP) return w;
    if (freq < LIMIT_B4) begin
      band = BAND_5; outdiv = 24;
    end else if (freq < LIMIT_B3) begin
      band = BAND_4; outdiv = 16;
    end else if (freq < LIMIT_B2) begin
      band = BAND_3; outdiv = 12;
    end else if (freq < LIMIT_B1) begin
      if (refclk < REF_SPLIT) begin
        band = BAND_0; outdiv = 4;
      end else begin
        band = BAND_2; outdiv = 8;
      end
    end else begin
      band = BAND_1; outdiv = 6;
    end
    pfd = (64'(refclk) * 2) / outdiv;
    if (pfd == 0) return w;
    quo = 64'(freq) / pfd;
    rem = 64'(freq) % pfd;
    if (quo == 0) return w;
    frac = (64'd1 << FRACTION_BITS) + ((rem << FRACTION_BITS) / pfd);
    w.band_code     = BAND_W'(BAND_OFFSET + BAND_W'(band));
    w.integer_word  = INT_W'(quo - 1);
    w.fraction_word = FRAC_W'(frac);
    w.range_error   = 1'b0;
    return w;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    synth_word_t want;
    if (rst) begin
      ref_hz = REF_RESET;
      divider_words_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) ref_hz = reference_clock_hz;
      if (freq_valid && !freq_stall)
        divider_words_q.push_back(calc_divider_word(target_freq_hz, ref_hz));
      if (word_valid && !word_stall) begin
        if (divider_words_q.size() == 0) begin
          fail_count++;
          $display("%0t: word with none expected, expected none, actual %0d/%0d/%0d/%0d",
                   $time, band_code, integer_word, fraction_word, range_error);
        end else begin
          want = divider_words_q.pop_front();
          if (band_code !== want.band_code)
            flag_field("band_code", want.band_code, band_code);
          if (integer_word !== want.integer_word)
            flag_field("integer_word", want.integer_word, integer_word);
          if (fraction_word !== want.fraction_word)
            flag_field("fraction_word", want.fraction_word, fraction_word);
          if (range_error !== want.range_error)
            flag_field("range_error", want.range_error, range_error);
        end
      end
    end
    pending <= divider_words_q.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_fractional_n_synth_word_calc.sv =====
// ----------------------------------------------------------------------------
// tb_fractional_n_synth_word_calc: testbench of the synthesizer word calculator
// Sweeps the reference clock over several values (reset value, range ends,
// the 24 MHz split, zero and full scale) and sends directed and random
// carrier frequencies with random gaps and result stalls; the checker module
// predicts and compares every word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fractional_n_synth_word_calc;
  timeunit 1ns;
  timeprecision 1ps;

  import fnswc_pkg::*;

  localparam int FRAC_BITS   = FRACTION_BITS_DEFAULT;
  localparam int N_PHASES    = 10;
  localparam int RAND_WORDS  = 80;   // random words per reference setting
  localparam int LONG_HOLD   = 300;  // well past the pipeline depth
  localparam int DRAIN_WAIT  = FRAC_BITS + 40;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [REF_W-1:0]    reference_clock_hz;
  logic                freq_valid;
  logic                freq_stall;
  logic [FREQ_W-1:0]   target_freq_hz;
  logic                word_valid;
  logic                word_stall;
  logic [BAND_W-1:0]   band_code;
  logic [INT_W-1:0]    integer_word;
  logic [FRAC_W-1:0]   fraction_word;
  logic                range_error;

  int                  pending;
  int                  fail_count;
  logic                hold_off_req = 1'b0;

  fractional_n_synth_word_calc #(
    .FRACTION_BITS (FRAC_BITS)
  ) i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .reference_clock_hz (reference_clock_hz),
    .freq_valid         (freq_valid),
    .freq_stall         (freq_stall),
    .target_freq_hz     (target_freq_hz),
    .word_valid         (word_valid),
    .word_stall         (word_stall),
    .band_code          (band_code),
    .integer_word       (integer_word),
    .fraction_word      (fraction_word),
    .range_error        (range_error)
  );

  fnswc_word_checker #(
    .FRACTION_BITS (FRAC_BITS)
  ) i_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .reference_clock_hz (reference_clock_hz),
    .freq_valid         (freq_valid),
    .freq_stall         (freq_stall),
    .target_freq_hz     (target_freq_hz),
    .word_valid         (word_valid),
    .word_stall         (word_stall),
    .band_code          (band_code),
    .integer_word       (integer_word),
    .fraction_word      (fraction_word),
    .range_error        (range_error),
    .pending            (pending),
    .fail_count         (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; the slowest correct run is far shorter than this
  initial begin
    #5ms;
    $display("fractional_n_synth_word_calc test failed");
    $finish;
  end

  // Length of an idle stretch: usually from the short range, one time in five long
  function automatic int idle_len();
    if ($urandom_range(0, 4) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Length of a busy stretch: sometimes long runs with no idling at all
  function automatic int busy_len();
    if ($urandom_range(0, 3) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, 8);
  endfunction

  // Carrier frequency: full 30-bit range, the legal band range, values just
  // around every band threshold, and small ones, some of which leave the quotient zero
  function automatic logic [FREQ_W-1:0] pick_carrier();
    logic [FREQ_W-1:0] edge_hz;
    case ($urandom_range(0, 9))
      0, 1: return FREQ_W'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0:       edge_hz = LIMIT_TOP;
          1:       edge_hz = LIMIT_B1;
          2:       edge_hz = LIMIT_B2;
          3:       edge_hz = LIMIT_B3;
          default: edge_hz = LIMIT_B4;
        endcase
        return edge_hz + FREQ_W'($urandom_range(0, 2000)) - FREQ_W'(1000);
      end
      3:       return FREQ_W'($urandom_range(0, 4000000));
      default: return FREQ_W'($urandom_range(0, 704999999));
    endcase
  endfunction

  // Result side: random stalls, plus one long hold-off on request so the
  // pipeline fills up and pushes back on the request channel
  initial begin : result_side
    bit stalling;
    int run_left;
    stalling   = 1'b0;
    run_left   = 0;
    word_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        word_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        word_stall   <= 1'b0;
        hold_off_req = 1'b0;
        stalling     = 1'b0;
        run_left     = busy_len();
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          run_left = stalling ? idle_len() : busy_len();
        end
        word_stall <= stalling;
        run_left--;
      end
    end
  end

  int gap_free = 0;

  // Offer one frequency word and hold it until taken, then maybe idle
  task automatic send_freq(input logic [FREQ_W-1:0] hz);
    int gap;
    freq_valid     <= 1'b1;
    target_freq_hz <= hz;
    do @(posedge clk); while (freq_stall);
    if (gap_free > 0) begin
      gap_free--;
    end else begin
      gap      = idle_len();
      gap_free = busy_len();
      freq_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected word is back
  task automatic wait_drained();
    freq_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_ref(input logic [REF_W-1:0] hz);
    cfg_valid          <= 1'b1;
    reference_clock_hz <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [REF_W-1:0]  ref_plan [N_PHASES];
    logic [FREQ_W-1:0] directed [20];

    // Reference settings: reset value first (no write), range ends, both
    // sides of the 24 MHz split, zero (pfd zero everywhere), a tiny value
    // where only the low dividers give a nonzero pfd, and full scale
    ref_plan = '{REF_RESET, 26'd1000000, 26'd40000000, 26'd23999999, 26'd24000000,
                 26'd0, 26'd3, 26'h3FFFFFF, 26'd0, 26'd26000000};
    ref_plan[8] = REF_W'($urandom_range(1000000, 40000000));

    // At 26 MHz the lowest band has pfd 2166666: below it the quotient is
    // zero, at it the quotient is one; then every band edge and the top
    directed = '{30'd0, 30'd2166665, 30'd2166666, 30'd176999999, 30'd177000000,
                 30'd238999999, 30'd239000000, 30'd352999999, 30'd353000000,
                 30'd524999999, 30'd525000000, 30'd704999999, 30'd705000000,
                 30'h3FFFFFFF, 30'h2AAAAAAA, 30'h15555555, 30'd434000000,
                 30'd1, 30'd600000001, 30'd200000000};

    rst                <= 1'b1;
    cfg_valid          <= 1'b0;
    reference_clock_hz <= '0;
    freq_valid         <= 1'b0;
    target_freq_hz     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      // Change the reference only with the pipeline empty
      if (p > 0) begin
        wait_drained();
        write_ref(ref_plan[p]);
      end
      if (p == 0) begin
        foreach (directed[i]) send_freq(directed[i]);
      end
      for (int i = 0; i < RAND_WORDS; i++) begin
        // Long result hold-off while requests keep coming
        if (p == 2 && i == 5) hold_off_req = 1'b1;
        send_freq(pick_carrier());
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("fractional_n_synth_word_calc test passed");
    else
      $display("fractional_n_synth_word_calc test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/fnswc_pkg.sv
sv/fractional_n_synth_word_calc.sv
sv/fnswc_checker.sv
verif/fnswc_word_checker.sv
verif/tb_fractional_n_synth_word_calc.sv
